FILE: sv/swirl_source_coordinate_macros.svh
// Assertion macros for the swirl source-coordinate block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef SWIRL_SOURCE_COORDINATE_MACROS_SVH
`define SWIRL_SOURCE_COORDINATE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SCS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swirl_source_coordinate: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swirl_source_coordinate: next-cycle check failed");

`endif

FILE: sv/scs_pkg.sv
// Shared types and constants of the swirl source-coordinate pipeline.
// No dependencies; every file but the macro header refers to it by scoped names.
package scs_pkg;

    localparam int DIM_W      = 13;
    localparam int SCALE_W    = 24;
    localparam int COORD_W    = 12;
    localparam int SRC_W      = 14;
    localparam int OFS_W      = 14;
    localparam int SUMSQ_W    = 27;
    localparam int ROOT_W     = 22;
    localparam int RAD_W      = 44;
    localparam int REM_W      = 26;
    localparam int PROD_W     = 46;
    localparam int MOD_STEPS  = 13;
    localparam int TWO_PI_W   = 33;
    localparam int Z_W        = 35;
    localparam int C_W        = 34;
    localparam int TABLE_LEN  = 24;
    localparam int CFG_DATA_W = 24;

    localparam logic signed [Z_W-1:0] Q30_TWO_PI  = 35'sd6746518852;
    localparam logic signed [Z_W-1:0] Q30_PI      = 35'sd3373259426;
    localparam logic signed [Z_W-1:0] Q30_HALF_PI = 35'sd1686629713;
    localparam logic signed [C_W-1:0] Q30_GAIN    = 34'sd652032874;

    localparam logic [31:0] ATAN_Q30 [TABLE_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t REG_WIDTH  = 2'd0;
    localparam cfg_idx_t REG_HEIGHT = 2'd1;
    localparam cfg_idx_t REG_SCALE  = 2'd2;

    // Offset from the image center in half pixels.
    typedef struct packed {
        logic signed [OFS_W-1:0] dx2;
        logic signed [OFS_W-1:0] dy2;
    } ofs_t;

endpackage

FILE: sv/scs_sqrt.sv
// Sum of squares and a one-bit-per-stage integer square root pipeline.
// Depends on scs_pkg.
module scs_sqrt
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  scs_pkg::ofs_t             in_ofs,
    output logic                      out_valid,
    output scs_pkg::ofs_t             out_ofs,
    output logic [scs_pkg::ROOT_W-1:0] out_root
);

    localparam int NST = scs_pkg::ROOT_W;

    logic signed [2*scs_pkg::OFS_W-1:0] sqx;
    logic signed [2*scs_pkg::OFS_W-1:0] sqy;
    logic [scs_pkg::SUMSQ_W-1:0]        sumsq_next;
    logic [scs_pkg::SUMSQ_W-1:0]        sumsq_reg;
    logic                               sq_valid_reg;
    scs_pkg::ofs_t                      sq_ofs_reg;

    logic [scs_pkg::RAD_W-1:0]  rad_reg  [NST];
    logic [scs_pkg::REM_W-1:0]  rem_reg  [NST];
    logic [scs_pkg::ROOT_W-1:0] root_reg [NST];
    logic                       vld_reg  [NST];
    scs_pkg::ofs_t              ofs_reg  [NST];

    always_comb
    begin
        sqx        = in_ofs.dx2 * in_ofs.dx2;
        sqy        = in_ofs.dy2 * in_ofs.dy2;
        sumsq_next = scs_pkg::SUMSQ_W'(sqx) + scs_pkg::SUMSQ_W'(sqy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sq_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sumsq_reg  <= sumsq_next;
            sq_ofs_reg <= in_ofs;
        end
    end

    // Each stage brings down two radicand bits and settles one root bit.
    for (genvar k = 0; k < NST; k++)
    begin : g_stage
        logic [scs_pkg::RAD_W-1:0]  rad_src;
        logic [scs_pkg::REM_W-1:0]  rem_src;
        logic [scs_pkg::ROOT_W-1:0] root_src;
        logic                       vld_src;
        scs_pkg::ofs_t              ofs_src;
        logic [scs_pkg::REM_W-1:0]  rem_sh;
        logic [scs_pkg::REM_W-1:0]  trial;
        logic [scs_pkg::REM_W-1:0]  rem_next;
        logic [scs_pkg::ROOT_W-1:0] root_next;

        if (k == 0)
        begin : g_first
            assign rad_src  = {1'b0, sumsq_reg, 16'd0};
            assign rem_src  = '0;
            assign root_src = '0;
            assign vld_src  = sq_valid_reg;
            assign ofs_src  = sq_ofs_reg;
        end
        else
        begin : g_rest
            assign rad_src  = rad_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign root_src = root_reg[k-1];
            assign vld_src  = vld_reg[k-1];
            assign ofs_src  = ofs_reg[k-1];
        end

        always_comb
        begin
            rem_sh = {rem_src[scs_pkg::REM_W-3:0], rad_src[scs_pkg::RAD_W-1 -: 2]};
            trial  = scs_pkg::REM_W'({root_src, 2'b01});
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_src[scs_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_src[scs_pkg::ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k] <= vld_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rad_reg[k]  <= rad_src << 2;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                ofs_reg[k]  <= ofs_src;
            end
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out_ofs   = ofs_reg[NST-1];
    assign out_root  = root_reg[NST-1];

endmodule

FILE: sv/scs_angle.sv
// Twist angle: scale times distance, reduction modulo two pi by
// compare-subtract stages, and the fold into [-pi/2, pi/2]. Depends on scs_pkg.
module scs_angle
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    input  scs_pkg::ofs_t                     in_ofs,
    input  logic [scs_pkg::ROOT_W-1:0]        in_root,
    input  logic [scs_pkg::SCALE_W-1:0]       angle_scale,
    output logic                              out_valid,
    output scs_pkg::ofs_t                     out_ofs,
    output logic signed [scs_pkg::Z_W-1:0]    out_z,
    output logic                              out_flip
);

    localparam int NST = scs_pkg::MOD_STEPS;

    logic [scs_pkg::PROD_W-1:0] prod_reg;
    logic                       m_valid_reg;
    scs_pkg::ofs_t              m_ofs_reg;

    logic [scs_pkg::PROD_W-1:0] md_reg  [NST];
    logic                       vld_reg [NST];
    scs_pkg::ofs_t              ofs_reg [NST];

    logic signed [scs_pkg::Z_W-1:0] z0;
    logic signed [scs_pkg::Z_W-1:0] zr;
    logic signed [scs_pkg::Z_W-1:0] z_next;
    logic                           flip_next;
    logic signed [scs_pkg::Z_W-1:0] z_reg;
    logic                           flip_reg;
    logic                           f_valid_reg;
    scs_pkg::ofs_t                  f_ofs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= in_valid;
            f_valid_reg <= vld_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= scs_pkg::PROD_W'(angle_scale) * scs_pkg::PROD_W'(in_root);
            m_ofs_reg <= in_ofs;
        end
    end

    // Stage j removes two pi times 2^(NST-1-j) when it fits.
    for (genvar j = 0; j < NST; j++)
    begin : g_mod
        localparam logic [scs_pkg::PROD_W-1:0] SUB =
            scs_pkg::PROD_W'(scs_pkg::Q30_TWO_PI) << (NST - 1 - j);
        logic [scs_pkg::PROD_W-1:0] md_src;
        logic                       vld_src;
        scs_pkg::ofs_t              ofs_src;

        if (j == 0)
        begin : g_first
            assign md_src  = {1'b0, prod_reg[scs_pkg::PROD_W-1:1]};
            assign vld_src = m_valid_reg;
            assign ofs_src = m_ofs_reg;
        end
        else
        begin : g_rest
            assign md_src  = md_reg[j-1];
            assign vld_src = vld_reg[j-1];
            assign ofs_src = ofs_reg[j-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[j] <= vld_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                md_reg[j]  <= (md_src >= SUB) ? md_src - SUB : md_src;
                ofs_reg[j] <= ofs_src;
            end
        end
    end

    // Fold angles past a quarter turn back by pi, flipping the result vector.
    always_comb
    begin
        z0 = $signed({2'b00, md_reg[NST-1][scs_pkg::TWO_PI_W-1:0]});
        zr = (z0 > scs_pkg::Q30_PI) ? z0 - scs_pkg::Q30_TWO_PI : z0;
        if (zr > scs_pkg::Q30_HALF_PI)
        begin
            z_next    = zr - scs_pkg::Q30_PI;
            flip_next = 1'b1;
        end
        else if (zr < -scs_pkg::Q30_HALF_PI)
        begin
            z_next    = zr + scs_pkg::Q30_PI;
            flip_next = 1'b1;
        end
        else
        begin
            z_next    = zr;
            flip_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z_reg     <= z_next;
            flip_reg  <= flip_next;
            f_ofs_reg <= ofs_reg[NST-1];
        end
    end

    assign out_valid = f_valid_reg;
    assign out_ofs   = f_ofs_reg;
    assign out_z     = z_reg;
    assign out_flip  = flip_reg;

endmodule

FILE: sv/scs_cordic.sv
// Rotation-mode CORDIC, one iteration per stage, then the sign flip.
// Depends on scs_pkg.
module scs_cordic
#(
    parameter int STEPS = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           in_valid,
    input  scs_pkg::ofs_t                  in_ofs,
    input  logic signed [scs_pkg::Z_W-1:0] in_z,
    input  logic                           in_flip,
    output logic                           out_valid,
    output scs_pkg::ofs_t                  out_ofs,
    output logic signed [scs_pkg::C_W-1:0] out_cx,
    output logic signed [scs_pkg::C_W-1:0] out_cy
);

    logic signed [scs_pkg::C_W-1:0] cx_reg   [STEPS];
    logic signed [scs_pkg::C_W-1:0] cy_reg   [STEPS];
    logic signed [scs_pkg::Z_W-1:0] z_reg    [STEPS];
    logic                           flip_reg [STEPS];
    logic                           vld_reg  [STEPS];
    scs_pkg::ofs_t                  ofs_reg  [STEPS];

    logic signed [scs_pkg::C_W-1:0] fcx_reg;
    logic signed [scs_pkg::C_W-1:0] fcy_reg;
    logic                           f_valid_reg;
    scs_pkg::ofs_t                  f_ofs_reg;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_iter
        localparam logic signed [scs_pkg::Z_W-1:0] ATAN =
            $signed(scs_pkg::Z_W'(scs_pkg::ATAN_Q30[i]));
        logic signed [scs_pkg::C_W-1:0] cx_src;
        logic signed [scs_pkg::C_W-1:0] cy_src;
        logic signed [scs_pkg::Z_W-1:0] z_src;
        logic                           flip_src;
        logic                           vld_src;
        scs_pkg::ofs_t                  ofs_src;

        if (i == 0)
        begin : g_first
            assign cx_src   = scs_pkg::Q30_GAIN;
            assign cy_src   = '0;
            assign z_src    = in_z;
            assign flip_src = in_flip;
            assign vld_src  = in_valid;
            assign ofs_src  = in_ofs;
        end
        else
        begin : g_rest
            assign cx_src   = cx_reg[i-1];
            assign cy_src   = cy_reg[i-1];
            assign z_src    = z_reg[i-1];
            assign flip_src = flip_reg[i-1];
            assign vld_src  = vld_reg[i-1];
            assign ofs_src  = ofs_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[i] <= vld_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!z_src[scs_pkg::Z_W-1])
                begin
                    cx_reg[i] <= cx_src - (cy_src >>> i);
                    cy_reg[i] <= cy_src + (cx_src >>> i);
                    z_reg[i]  <= z_src - ATAN;
                end
                else
                begin
                    cx_reg[i] <= cx_src + (cy_src >>> i);
                    cy_reg[i] <= cy_src - (cx_src >>> i);
                    z_reg[i]  <= z_src + ATAN;
                end
                flip_reg[i] <= flip_src;
                ofs_reg[i]  <= ofs_src;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_valid_reg <= vld_reg[STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fcx_reg   <= flip_reg[STEPS-1] ? -cx_reg[STEPS-1] : cx_reg[STEPS-1];
            fcy_reg   <= flip_reg[STEPS-1] ? -cy_reg[STEPS-1] : cy_reg[STEPS-1];
            f_ofs_reg <= ofs_reg[STEPS-1];
        end
    end

    assign out_valid = f_valid_reg;
    assign out_ofs   = f_ofs_reg;
    assign out_cx    = fcx_reg;
    assign out_cy    = fcy_reg;

endmodule

FILE: sv/swirl_source_coordinate.sv
// The pipeline holds the 22-stage root, the 13-stage modulo reduction
// and one stage per CORDIC iteration, among its other registers.
// Throughput is one beat per cycle; the whole pipeline holds while a result is stalled.
// Reset (async, active low) clears all valid bits and loads width 600, height 600,
// angle scale 21961; data registers are not reset.
module swirl_source_coordinate
#(
    parameter int MAX_DIM      = 4096,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [scs_pkg::COORD_W-1:0]         dest_x,
    input  logic [scs_pkg::COORD_W-1:0]         dest_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [scs_pkg::SRC_W-1:0]    src_x,
    output logic signed [scs_pkg::SRC_W-1:0]    src_y,
    output logic                                inside_res,
    input  logic                                cfg_write,
    input  scs_pkg::cfg_idx_t                   cfg_index,
    input  logic [scs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int P_W  = scs_pkg::OFS_W + scs_pkg::C_W;
    localparam int T_W  = P_W + 2;
    localparam int SX_W = T_W - 31;
    localparam logic signed [SX_W-1:0] SRC_MIN = -(SX_W'(1) <<< (scs_pkg::SRC_W - 1));
    localparam logic signed [SX_W-1:0] SRC_MAX = (SX_W'(1) <<< (scs_pkg::SRC_W - 1)) - 1;

    logic [scs_pkg::DIM_W-1:0]   width_reg;
    logic [scs_pkg::DIM_W-1:0]   height_reg;
    logic [scs_pkg::SCALE_W-1:0] scale_reg;
    logic [scs_pkg::DIM_W-1:0]   dim_next;

    logic          adv;
    scs_pkg::ofs_t in_ofs;

    logic                              r_valid;
    scs_pkg::ofs_t                     r_ofs;
    logic [scs_pkg::ROOT_W-1:0]        r_root;
    logic                              a_valid;
    scs_pkg::ofs_t                     a_ofs;
    logic signed [scs_pkg::Z_W-1:0]    a_z;
    logic                              a_flip;
    logic                              c_valid;
    scs_pkg::ofs_t                     c_ofs;
    logic signed [scs_pkg::C_W-1:0]    c_cx;
    logic signed [scs_pkg::C_W-1:0]    c_cy;

    logic signed [P_W-1:0] pxx_reg;
    logic signed [P_W-1:0] pyy_reg;
    logic signed [P_W-1:0] pxy_reg;
    logic signed [P_W-1:0] pyx_reg;
    logic                  p_valid_reg;
    logic signed [T_W-1:0] tx_reg;
    logic signed [T_W-1:0] ty_reg;
    logic                  t_valid_reg;

    logic signed [SX_W-1:0] qx;
    logic signed [SX_W-1:0] qy;
    logic                   in_next;

    logic signed [scs_pkg::SRC_W-1:0] src_x_reg;
    logic signed [scs_pkg::SRC_W-1:0] src_y_reg;
    logic                             inside_reg;
    logic                             out_valid_reg;

    // Dimensions come from the low DIM_W bits of cfg_data; above MAX_DIM they are held at MAX_DIM.
    always_comb
    begin
        if (32'(cfg_data[scs_pkg::DIM_W-1:0]) > 32'(MAX_DIM))
        begin
            dim_next = scs_pkg::DIM_W'(MAX_DIM);
        end
        else
        begin
            dim_next = cfg_data[scs_pkg::DIM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd600;
            height_reg <= 13'd600;
            scale_reg  <= 24'd21961;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                scs_pkg::REG_WIDTH:  width_reg  <= dim_next;
                scs_pkg::REG_HEIGHT: height_reg <= dim_next;
                scs_pkg::REG_SCALE:  scale_reg  <= cfg_data[scs_pkg::SCALE_W-1:0];
                default:             ;
            endcase
        end
    end

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    assign in_ofs.dx2 = $signed({1'b0, dest_x, 1'b0}) - $signed({1'b0, width_reg});
    assign in_ofs.dy2 = $signed({1'b0, dest_y, 1'b0}) - $signed({1'b0, height_reg});

    scs_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .in_ofs    (in_ofs),
        .out_valid (r_valid),
        .out_ofs   (r_ofs),
        .out_root  (r_root)
    );

    scs_angle u_angle
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (r_valid),
        .in_ofs      (r_ofs),
        .in_root     (r_root),
        .angle_scale (scale_reg),
        .out_valid   (a_valid),
        .out_ofs     (a_ofs),
        .out_z       (a_z),
        .out_flip    (a_flip)
    );

    scs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (a_valid),
        .in_ofs    (a_ofs),
        .in_z      (a_z),
        .in_flip   (a_flip),
        .out_valid (c_valid),
        .out_ofs   (c_ofs),
        .out_cx    (c_cx),
        .out_cy    (c_cy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            t_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_valid_reg   <= c_valid;
            t_valid_reg   <= p_valid_reg;
            out_valid_reg <= t_valid_reg;
        end
    end

    // Sums are in units of 2^-31 pixel: half-pixel offsets times Q.30.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pxx_reg <= c_ofs.dx2 * c_cx;
            pyy_reg <= c_ofs.dy2 * c_cy;
            pxy_reg <= c_ofs.dx2 * c_cy;
            pyx_reg <= c_ofs.dy2 * c_cx;
            tx_reg  <= $signed({{(T_W - scs_pkg::DIM_W - 30){1'b0}}, width_reg, 30'd0})
                       + T_W'(pxx_reg) - T_W'(pyy_reg);
            ty_reg  <= $signed({{(T_W - scs_pkg::DIM_W - 30){1'b0}}, height_reg, 30'd0})
                       + T_W'(pxy_reg) + T_W'(pyx_reg);
        end
    end

    // Divide by 2^31 with truncation toward zero, then bound-check and saturate.
    always_comb
    begin
        qx = $signed(tx_reg[T_W-1:31])
             + $signed(SX_W'(tx_reg[T_W-1] && (|tx_reg[30:0])));
        qy = $signed(ty_reg[T_W-1:31])
             + $signed(SX_W'(ty_reg[T_W-1] && (|ty_reg[30:0])));
        in_next = !qx[SX_W-1] && !qy[SX_W-1]
                  && (qx < $signed({{(SX_W - scs_pkg::DIM_W){1'b0}}, width_reg}))
                  && (qy < $signed({{(SX_W - scs_pkg::DIM_W){1'b0}}, height_reg}));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (qx < SRC_MIN)
            begin
                src_x_reg <= SRC_MIN[scs_pkg::SRC_W-1:0];
            end
            else if (qx > SRC_MAX)
            begin
                src_x_reg <= SRC_MAX[scs_pkg::SRC_W-1:0];
            end
            else
            begin
                src_x_reg <= qx[scs_pkg::SRC_W-1:0];
            end
            if (qy < SRC_MIN)
            begin
                src_y_reg <= SRC_MIN[scs_pkg::SRC_W-1:0];
            end
            else if (qy > SRC_MAX)
            begin
                src_y_reg <= SRC_MAX[scs_pkg::SRC_W-1:0];
            end
            else
            begin
                src_y_reg <= qy[scs_pkg::SRC_W-1:0];
            end
            inside_reg <= in_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign src_x      = src_x_reg;
    assign src_y      = src_y_reg;
    assign inside_res = inside_reg;

`include "swirl_source_coordinate_macros.svh"

    `SCS_ASSERT_IMP(a_inside_x, out_valid && inside_res,
        !src_x[scs_pkg::SRC_W-1] && (src_x[scs_pkg::DIM_W-1:0] < width_reg))
    `SCS_ASSERT_IMP(a_inside_y, out_valid && inside_res,
        !src_y[scs_pkg::SRC_W-1] && (src_y[scs_pkg::DIM_W-1:0] < height_reg))
    `SCS_ASSERT_NEXT(a_dim_limit, cfg_write,
        (32'(width_reg) <= 32'(MAX_DIM)) || (32'(height_reg) <= 32'(MAX_DIM)))

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the swirl source-coordinate block.
// Depends on scs_pkg and swirl_source_coordinate; it predicts each source
// coordinate in a scoreboard and compares it with every output beat.
`timescale 1ns / 1ps

typedef struct {
    logic signed [scs_pkg::SRC_W-1:0] src_x;
    logic signed [scs_pkg::SRC_W-1:0] src_y;
    logic                             in_img;
} swirl_src_t;

class swirl_scoreboard;
    longint unsigned width  = 600;
    longint unsigned height = 600;
    longint unsigned scale  = 21961;
    swirl_src_t      pending[$];
    int              errors = 0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned limit_dim(longint unsigned v);
        v = v & 64'h1FFF;
        return (v > 4096) ? 4096 : v;
    endfunction

    function automatic void write_reg(scs_pkg::cfg_idx_t idx, longint unsigned v);
        if (idx == scs_pkg::REG_WIDTH)
            width = limit_dim(v);
        else if (idx == scs_pkg::REG_HEIGHT)
            height = limit_dim(v);
        else if (idx == scs_pkg::REG_SCALE)
            scale = v & 64'hFFFFFF;
    endfunction

    function automatic longint sat(longint v);
        if (v < -8192)
            return -8192;
        if (v > 8191)
            return 8191;
        return v;
    endfunction

    // Works out the swirled source pixel for one destination beat.
    function automatic void note_input(logic [11:0] x, logic [11:0] y);
        longint          w, h, dx2, dy2, z, cx, cy, nx, ny, t, sx, sy;
        longint unsigned sumsq, r, turn;
        bit              flip;
        swirl_src_t      e;
        w     = longint'(width);
        h     = longint'(height);
        dx2   = 2 * longint'(x) - w;
        dy2   = 2 * longint'(y) - h;
        sumsq = longint'(dx2 * dx2) + longint'(dy2 * dy2);
        r     = int_sqrt(sumsq << 16);
        turn  = ((scale * r) >> 1) % longint'(scs_pkg::Q30_TWO_PI);
        z     = longint'(turn);
        flip  = 0;
        if (z > longint'(scs_pkg::Q30_PI))
            z = z - longint'(scs_pkg::Q30_TWO_PI);
        if (z > longint'(scs_pkg::Q30_HALF_PI))
        begin
            z    = z - longint'(scs_pkg::Q30_PI);
            flip = 1;
        end
        else if (z < -longint'(scs_pkg::Q30_HALF_PI))
        begin
            z    = z + longint'(scs_pkg::Q30_PI);
            flip = 1;
        end
        cx = longint'(scs_pkg::Q30_GAIN);
        cy = 0;
        for (int i = 0; i < 16; i++)
        begin
            if (z >= 0)
            begin
                nx = cx - (cy >>> i);
                ny = cy + (cx >>> i);
                z  = z - longint'(scs_pkg::ATAN_Q30[i]);
            end
            else
            begin
                nx = cx + (cy >>> i);
                ny = cy - (cx >>> i);
                z  = z + longint'(scs_pkg::ATAN_Q30[i]);
            end
            cx = nx;
            cy = ny;
        end
        if (flip)
        begin
            cx = -cx;
            cy = -cy;
        end
        // Half-pixel offsets times Q.30 give units of 2^-31 pixel.
        t  = w * 64'sd1073741824 + dx2 * cx - dy2 * cy;
        sx = t / 64'sd2147483648;
        t  = h * 64'sd1073741824 + dx2 * cy + dy2 * cx;
        sy = t / 64'sd2147483648;
        e.src_x  = scs_pkg::SRC_W'(sat(sx));
        e.src_y  = scs_pkg::SRC_W'(sat(sy));
        e.in_img = (sx >= 0 && sy >= 0 && sx < w && sy < h);
        pending.push_back(e);
    endfunction

    function automatic void check_result(logic signed [13:0] sx, logic signed [13:0] sy,
                                         logic ins);
        swirl_src_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected output beat: src_x %0d src_y %0d", sx, sy);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (sx !== e.src_x)
        begin
            $error("src_x: expected %0d, actual %0d", e.src_x, sx);
            errors++;
        end
        if (sy !== e.src_y)
        begin
            $error("src_y: expected %0d, actual %0d", e.src_y, sy);
            errors++;
        end
        if (ins !== e.in_img)
        begin
            $error("inside_res: expected %0d, actual %0d", e.in_img, ins);
            errors++;
        end
    endfunction
endclass

module testbench;

    localparam int LATENCY = 58;
    localparam longint CYCLE_LIMIT = 3000000;

    logic                                 clk = 0;
    logic                                 rst_n = 0;
    logic                                 in_valid = 0;
    logic                                 in_stall;
    logic [scs_pkg::COORD_W-1:0]          dest_x = '0;
    logic [scs_pkg::COORD_W-1:0]          dest_y = '0;
    logic                                 out_valid;
    logic                                 out_stall = 0;
    logic signed [scs_pkg::SRC_W-1:0]     src_x;
    logic signed [scs_pkg::SRC_W-1:0]     src_y;
    logic                                 inside_res;
    logic                                 cfg_write = 0;
    scs_pkg::cfg_idx_t                    cfg_index = scs_pkg::REG_WIDTH;
    logic [scs_pkg::CFG_DATA_W-1:0]       cfg_data = '0;

    swirl_scoreboard swirl_sb = new();
    longint          cycles = 0;
    int              stall_left = 0;
    bit              stall_on = 1;

    swirl_source_coordinate u_top (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            swirl_sb.note_input(dest_x, dest_y);
        if (out_valid && !out_stall)
            swirl_sb.check_result(src_x, src_y, inside_res);
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 60)
            return 0;
        if (p < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    // The receiver stalls in bursts of random length, or not at all.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1;
        end
        else
        begin
            out_stall <= 0;
            if (stall_on && $urandom_range(3) == 0)
                stall_left <= pick_gap();
        end
    end

    task automatic send_beat(logic [11:0] x, logic [11:0] y);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 0;
            dest_x   <= scs_pkg::COORD_W'($urandom);
            dest_y   <= scs_pkg::COORD_W'($urandom);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        dest_x   <= x;
        dest_y   <= y;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (swirl_sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_cfg(scs_pkg::cfg_idx_t idx, logic [23:0] v);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 0;
        swirl_sb.write_reg(idx, longint'(v));
    endtask

    task automatic random_beats(int n);
        logic [11:0] x, y;
        for (int i = 0; i < n; i++)
        begin
            // Mostly pixels in the image, the rest anywhere in the field.
            if ($urandom_range(3) != 0 && swirl_sb.width > 0 && swirl_sb.height > 0)
            begin
                x = 12'($urandom_range(32'(swirl_sb.width - 1)));
                y = 12'($urandom_range(32'(swirl_sb.height - 1)));
            end
            else
            begin
                x = 12'($urandom);
                y = 12'($urandom);
            end
            send_beat(x, y);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Reset settings: corners, center, field extremes.
        send_beat(0, 0);
        send_beat(4095, 4095);
        send_beat(0, 4095);
        send_beat(4095, 0);
        send_beat(300, 300);
        send_beat(299, 300);
        send_beat(599, 599);
        send_beat(600, 600);
        send_beat(12'hAAA, 12'h555);
        send_beat(12'h555, 12'hAAA);
        random_beats(100);
        drain();

        // Smallest image with no twist.
        write_cfg(scs_pkg::REG_WIDTH, 1);
        write_cfg(scs_pkg::REG_HEIGHT, 1);
        write_cfg(scs_pkg::REG_SCALE, 0);
        send_beat(0, 0);
        send_beat(1, 1);
        send_beat(4095, 4095);
        random_beats(60);
        drain();

        // Largest image and scale, with dimensions written above the limit.
        stall_on = 0;
        write_cfg(scs_pkg::REG_WIDTH, 24'hFFFFFF);
        write_cfg(scs_pkg::REG_HEIGHT, 24'h1FFF);
        write_cfg(scs_pkg::REG_SCALE, 24'hFFFFFF);
        send_beat(0, 0);
        send_beat(4095, 4095);
        send_beat(2048, 2048);
        random_beats(120);
        drain();
        stall_on = 1;

        // Zero dimensions; the unused register index must be ignored.
        write_cfg(scs_pkg::REG_WIDTH, 0);
        write_cfg(scs_pkg::REG_HEIGHT, 0);
        write_cfg(scs_pkg::cfg_idx_t'(3), 24'h123456);
        write_cfg(scs_pkg::REG_SCALE, 274517);
        send_beat(0, 0);
        send_beat(4095, 0);
        random_beats(80);
        drain();

        write_cfg(scs_pkg::REG_WIDTH, 64);
        write_cfg(scs_pkg::REG_HEIGHT, 48);
        write_cfg(scs_pkg::REG_SCALE, 274517);
        random_beats(160);
        drain();

        write_cfg(scs_pkg::REG_WIDTH, 4097);
        write_cfg(scs_pkg::REG_HEIGHT, 13);
        write_cfg(scs_pkg::REG_SCALE, 1000000);
        random_beats(120);
        drain();

        for (int k = 0; k < 4; k++)
        begin
            stall_on = k[0];
            write_cfg(scs_pkg::REG_WIDTH, 24'($urandom_range(4096, 1)));
            write_cfg(scs_pkg::REG_HEIGHT, 24'($urandom_range(4096, 1)));
            write_cfg(scs_pkg::REG_SCALE, 24'($urandom));
            random_beats(100);
            drain();
        end

        if (swirl_sb.errors == 0 && swirl_sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
